@@ rtl/core/dnsa_pkg.sv @@
package dnsa_pkg;

  localparam int NAME_DEPTH_DEF = 256;
  localparam int MAX_PACKET_DEF = 4096;

  localparam logic [3:0] PH_HEADER = 4'd0;
  localparam logic [3:0] PH_QSTART = 4'd1;
  localparam logic [3:0] PH_QLEN   = 4'd2;
  localparam logic [3:0] PH_QLABEL = 4'd3;
  localparam logic [3:0] PH_QTAIL  = 4'd4;
  localparam logic [3:0] PH_RSTART = 4'd5;
  localparam logic [3:0] PH_RPTR   = 4'd6;
  localparam logic [3:0] PH_RLEN   = 4'd7;
  localparam logic [3:0] PH_RLABEL = 4'd8;
  localparam logic [3:0] PH_FIXED  = 4'd9;
  localparam logic [3:0] PH_RDATA  = 4'd10;
  localparam logic [3:0] PH_DONE   = 4'd11;
  localparam logic [3:0] PH_SKIP   = 4'd12;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RCODE    = 2'd1;
  localparam logic [1:0] ST_MISMATCH = 2'd2;
  localparam logic [1:0] ST_TRUNC    = 2'd3;

  localparam logic OP_NAME   = 1'b0;
  localparam logic OP_PACKET = 1'b1;

  typedef struct packed {
    logic        rec;
    logic [31:0] address;
    logic [31:0] lifetime;
    logic        fin;
    logic [1:0]  status;
  } dnsa_ev_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] address;
    logic [31:0] lifetime;
    logic [1:0]  status;
    logic        final_res;
  } dnsa_res_t;

endpackage

@@ rtl/core/dns_response_a_record_parser.sv @@
// DNS response A-record parser.
// Input stream: each transfer carries one byte. tuser = 0 loads a byte of the
// expected query name as dotted text, tuser = 1 is a byte of a DNS response;
// tlast ends the name or the packet.
// Output stream: one transfer per type-A record (address, TTL) and one final
// status transfer per packet with tlast set (0 ok, 1 not a response or rcode
// error, 2 name mismatch, 3 truncated).
// Throughput is one input byte per cycle while in_tready is high. The byte that
// completes a record or ends a packet writes its result into a registered
// four-entry queue; a byte that yields both a record and a status drains as
// two output transfers, the record first.
// When the receiver stalls the queue fills and in_tready drops once fewer than
// two entries are free, so no result is lost.
// Reset clears the packet walk, the name length and the queue; the stored name
// text itself is not cleared and only entries written are compared.
module dns_response_a_record_parser #(
  parameter int NAME_DEPTH = dnsa_pkg::NAME_DEPTH_DEF,
  parameter int MAX_PACKET = dnsa_pkg::MAX_PACKET_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic        in_tuser,   // operation
  input  logic        in_tlast,   // last
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,  // address[31:0], lifetime[63:32], status[65:64]
  output logic        out_tuser,  // kind
  output logic        out_tlast   // final_res
);

  logic               acc, ev_valid, room, q_valid, pop;
  dnsa_pkg::dnsa_ev_t ev, q_data;
  dnsa_pkg::dnsa_res_t res;

  assign in_tready = room;
  assign acc = in_tvalid && room;

  dnsa_front #(.NAME_DEPTH(NAME_DEPTH), .MAX_PACKET(MAX_PACKET)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(acc), .op(in_tuser),
    .data_byte(in_tdata), .last(in_tlast), .ev_valid(ev_valid), .ev(ev)
  );

  dnsa_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .wr_en(ev_valid), .wr_data(ev),
    .has_room(room), .rd_valid(q_valid), .rd_data(q_data), .rd_en(pop)
  );

  dnsa_back u_back (
    .clk(clk), .rst_n(rst_n), .ev_valid(q_valid), .ev(q_data), .ev_pop(pop),
    .out_valid(out_tvalid), .res(res), .out_ready(out_tready)
  );

  assign out_tdata = {6'd0, res.status, res.lifetime, res.address};
  assign out_tuser = res.kind;
  assign out_tlast = res.final_res;

endmodule

@@ rtl/core/dnsa_front.sv @@
module dnsa_front #(
  parameter int NAME_DEPTH = dnsa_pkg::NAME_DEPTH_DEF,
  parameter int MAX_PACKET = dnsa_pkg::MAX_PACKET_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               op,
  input  logic [7:0]         data_byte,
  input  logic               last,
  output logic               ev_valid,
  output dnsa_pkg::dnsa_ev_t ev
);

  localparam int AW = $clog2(NAME_DEPTH);
  localparam int LW = AW + 1;
  localparam int PW = $clog2(MAX_PACKET + 1);

  logic [7:0]  name_mem [NAME_DEPTH];
  logic [LW-1:0] exp_len_r, cmp_pos_r, cmp_pos_nxt;
  logic        name_closed_r;
  logic [3:0]  phase_r, phase_nxt;
  logic [15:0] fpos_r, fpos_nxt;
  logic [15:0] q_left_r, q_left_nxt;
  logic [17:0] r_left_r, r_left_nxt;
  logic [7:0]  lab_r, lab_nxt;
  logic [15:0] rtype_r, rtype_nxt;
  logic [31:0] ttl_r, ttl_nxt;
  logic [15:0] dlen_r, dlen_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [1:0]  err_r, err_nxt;
  logic [PW-1:0] pcnt_r;
  logic        hit;
  logic [7:0]  exp_char_r;
  logic        char_ok, dot_ok;
  logic [15:0] fpos_inc;
  logic [LW-1:0] name_wlen;
  logic        name_we;
  logic [LW-1:0] cmp_pos_d;

  assign char_ok  = (cmp_pos_r < exp_len_r) && (exp_char_r == data_byte);
  assign dot_ok   = (cmp_pos_r < exp_len_r) && (exp_char_r == 8'h2E);
  assign fpos_inc = fpos_r + 16'd1;
  assign name_wlen = name_closed_r ? '0 : exp_len_r;
  assign name_we = in_valid && op == dnsa_pkg::OP_NAME && name_wlen < LW'(NAME_DEPTH);

  always_comb begin
    phase_nxt  = phase_r;
    fpos_nxt   = fpos_r;
    q_left_nxt = q_left_r;
    r_left_nxt = r_left_r;
    lab_nxt    = lab_r;
    cmp_pos_nxt = cmp_pos_r;
    rtype_nxt  = rtype_r;
    ttl_nxt    = ttl_r;
    dlen_nxt   = dlen_r;
    addr_nxt   = addr_r;
    err_nxt    = err_r;
    hit        = 1'b0;
    unique case (phase_r) inside
      dnsa_pkg::PH_HEADER: begin
        if (fpos_r == 16'd2 && !data_byte[7]) err_nxt = dnsa_pkg::ST_RCODE;
        if (fpos_r == 16'd3 && data_byte[3:0] != 4'd0) err_nxt = dnsa_pkg::ST_RCODE;
        if (fpos_r == 16'd4 || fpos_r == 16'd5) q_left_nxt = {q_left_r[7:0], data_byte};
        if (fpos_r >= 16'd6 && !fpos_r[0]) rtype_nxt = {8'd0, data_byte};
        if (fpos_r >= 16'd7 && fpos_r[0])
          r_left_nxt = r_left_r + {2'd0, rtype_r[7:0], data_byte};
        fpos_nxt = fpos_inc;
        if (fpos_inc == 16'd12) begin
          fpos_nxt = '0;
          rtype_nxt = '0;
          cmp_pos_nxt = '0;
          if (err_nxt != dnsa_pkg::ST_OK) phase_nxt = dnsa_pkg::PH_SKIP;
          else if (q_left_nxt != 16'd0) phase_nxt = dnsa_pkg::PH_QSTART;
          else phase_nxt = (r_left_nxt != 18'd0) ? dnsa_pkg::PH_RSTART
                                                  : dnsa_pkg::PH_DONE;
        end
      end
      dnsa_pkg::PH_QSTART, dnsa_pkg::PH_QLEN: begin
        if (phase_r == dnsa_pkg::PH_QSTART && data_byte[7:6] != 2'd0) begin
          err_nxt = dnsa_pkg::ST_MISMATCH;
          phase_nxt = dnsa_pkg::PH_SKIP;
        end else if (data_byte == 8'd0) begin
          if (cmp_pos_r != exp_len_r) begin
            err_nxt = dnsa_pkg::ST_MISMATCH;
            phase_nxt = dnsa_pkg::PH_SKIP;
          end else begin
            fpos_nxt = '0;
            phase_nxt = dnsa_pkg::PH_QTAIL;
          end
        end else if (phase_r == dnsa_pkg::PH_QLEN && !dot_ok) begin
          err_nxt = dnsa_pkg::ST_MISMATCH;
          phase_nxt = dnsa_pkg::PH_SKIP;
        end else begin
          if (phase_r == dnsa_pkg::PH_QLEN) cmp_pos_nxt = cmp_pos_r + LW'(1);
          lab_nxt = data_byte;
          phase_nxt = dnsa_pkg::PH_QLABEL;
        end
      end
      dnsa_pkg::PH_QLABEL: begin
        if (!char_ok) begin
          err_nxt = dnsa_pkg::ST_MISMATCH;
          phase_nxt = dnsa_pkg::PH_SKIP;
        end else begin
          cmp_pos_nxt = cmp_pos_r + LW'(1);
          lab_nxt = lab_r - 8'd1;
          if (lab_r == 8'd1) phase_nxt = dnsa_pkg::PH_QLEN;
        end
      end
      dnsa_pkg::PH_QTAIL: begin
        fpos_nxt = fpos_inc;
        if (fpos_inc == 16'd4) begin
          fpos_nxt = '0;
          cmp_pos_nxt = '0;
          q_left_nxt = q_left_r - 16'd1;
          if (q_left_r != 16'd1) phase_nxt = dnsa_pkg::PH_QSTART;
          else phase_nxt = (r_left_r != 18'd0) ? dnsa_pkg::PH_RSTART
                                                : dnsa_pkg::PH_DONE;
        end
      end
      dnsa_pkg::PH_RSTART, dnsa_pkg::PH_RLEN: begin
        if (phase_r == dnsa_pkg::PH_RSTART && data_byte[7:6] != 2'd0) begin
          phase_nxt = dnsa_pkg::PH_RPTR;
        end else begin
          fpos_nxt = '0;
          if (data_byte == 8'd0) phase_nxt = dnsa_pkg::PH_FIXED;
          else begin
            lab_nxt = data_byte;
            phase_nxt = dnsa_pkg::PH_RLABEL;
          end
        end
      end
      dnsa_pkg::PH_RPTR: begin
        fpos_nxt = '0;
        phase_nxt = dnsa_pkg::PH_FIXED;
      end
      dnsa_pkg::PH_RLABEL: begin
        lab_nxt = lab_r - 8'd1;
        if (lab_r == 8'd1) phase_nxt = dnsa_pkg::PH_RLEN;
      end
      dnsa_pkg::PH_FIXED: begin
        if (fpos_r < 16'd2) rtype_nxt = {rtype_r[7:0], data_byte};
        else if (fpos_r >= 16'd4 && fpos_r < 16'd8) ttl_nxt = {ttl_r[23:0], data_byte};
        else if (fpos_r >= 16'd8) dlen_nxt = {dlen_r[7:0], data_byte};
        fpos_nxt = fpos_inc;
        if (fpos_inc == 16'd10) begin
          fpos_nxt = '0;
          addr_nxt = '0;
          if (dlen_nxt == 16'd0) begin
            if (r_left_r != 18'd0) r_left_nxt = r_left_r - 18'd1;
            phase_nxt = (r_left_nxt != 18'd0) ? dnsa_pkg::PH_RSTART
                                               : dnsa_pkg::PH_DONE;
          end else begin
            phase_nxt = dnsa_pkg::PH_RDATA;
          end
        end
      end
      dnsa_pkg::PH_RDATA: begin
        if (fpos_r < 16'd4) addr_nxt = {addr_r[23:0], data_byte};
        fpos_nxt = fpos_inc;
        hit = (fpos_inc == 16'd4) && (rtype_r == 16'd1) && (dlen_r >= 16'd4);
        if (fpos_inc >= dlen_r) begin
          fpos_nxt = '0;
          if (r_left_r != 18'd0) r_left_nxt = r_left_r - 18'd1;
          phase_nxt = (r_left_nxt != 18'd0) ? dnsa_pkg::PH_RSTART
                                             : dnsa_pkg::PH_DONE;
        end
      end
      default: ;
    endcase
  end

  logic pkt, live;
  assign pkt  = in_valid && op == dnsa_pkg::OP_PACKET;
  assign live = pkt && (pcnt_r < PW'(MAX_PACKET));

  always_comb begin
    if (!rst_n || (pkt && last)) cmp_pos_d = '0;
    else if (live) cmp_pos_d = cmp_pos_nxt;
    else cmp_pos_d = cmp_pos_r;
  end

  // The expected character is registered from the compare position the next byte
  // sees; a name byte written to that entry in the same cycle is forwarded.
  always_ff @(posedge clk) begin
    if (name_we) name_mem[name_wlen[AW-1:0]] <= data_byte;
    if (name_we && name_wlen[AW-1:0] == cmp_pos_d[AW-1:0]) exp_char_r <= data_byte;
    else exp_char_r <= name_mem[cmp_pos_d[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_len_r <= '0;
      name_closed_r <= 1'b0;
      phase_r <= dnsa_pkg::PH_HEADER;
      fpos_r <= '0; q_left_r <= '0; r_left_r <= '0; lab_r <= '0;
      cmp_pos_r <= '0; rtype_r <= '0; ttl_r <= '0; dlen_r <= '0;
      addr_r <= '0; err_r <= '0; pcnt_r <= '0;
    end else begin
      if (in_valid && op == dnsa_pkg::OP_NAME) begin
        exp_len_r <= (name_wlen < LW'(NAME_DEPTH)) ? name_wlen + LW'(1) : name_wlen;
        name_closed_r <= last;
      end
      if (pkt && last) begin
        phase_r <= dnsa_pkg::PH_HEADER;
        fpos_r <= '0; q_left_r <= '0; r_left_r <= '0; lab_r <= '0;
        cmp_pos_r <= '0; rtype_r <= '0; ttl_r <= '0; dlen_r <= '0;
        addr_r <= '0; err_r <= '0; pcnt_r <= '0;
      end else if (live) begin
        pcnt_r <= pcnt_r + PW'(1);
        phase_r <= phase_nxt; fpos_r <= fpos_nxt; q_left_r <= q_left_nxt;
        r_left_r <= r_left_nxt; lab_r <= lab_nxt; cmp_pos_r <= cmp_pos_nxt;
        rtype_r <= rtype_nxt; ttl_r <= ttl_nxt; dlen_r <= dlen_nxt;
        addr_r <= addr_nxt; err_r <= err_nxt;
      end
    end
  end

  logic [3:0] ph_end;
  logic [1:0] err_end;
  assign ph_end  = live ? phase_nxt : phase_r;
  assign err_end = live ? err_nxt : err_r;

  always_comb begin
    ev.rec      = live && hit;
    ev.address  = addr_nxt;
    ev.lifetime = ttl_r;
    ev.fin      = pkt && last;
    if (err_end != dnsa_pkg::ST_OK) ev.status = err_end;
    else if (ph_end == dnsa_pkg::PH_DONE) ev.status = dnsa_pkg::ST_OK;
    else ev.status = dnsa_pkg::ST_TRUNC;
    ev_valid = ev.rec || ev.fin;
  end

endmodule

@@ rtl/core/dnsa_fifo.sv @@
module dnsa_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  dnsa_pkg::dnsa_ev_t wr_data,
  output logic               has_room,
  output logic               rd_valid,
  output dnsa_pkg::dnsa_ev_t rd_data,
  input  logic               rd_en
);

  dnsa_pkg::dnsa_ev_t mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign rd_valid = cnt_r != 3'd0;
  assign rd_data  = mem_r[rp_r];
  assign has_room = cnt_r <= 3'd2;

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 2'd1;
      if (rd_en) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'd0, wr_en} - {2'd0, rd_en};
    end
  end

endmodule

@@ rtl/core/dnsa_back.sv @@
module dnsa_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                ev_valid,
  input  dnsa_pkg::dnsa_ev_t  ev,
  output logic                ev_pop,
  output logic                out_valid,
  output dnsa_pkg::dnsa_res_t res,
  input  logic                out_ready
);

  // An entry may carry a record and a status; the record goes first.
  logic rec_done_r;
  logic send_rec;

  assign send_rec  = ev.rec && !rec_done_r;
  assign out_valid = ev_valid;

  always_comb begin
    if (send_rec) begin
      res.kind = 1'b0;
      res.address = ev.address;
      res.lifetime = ev.lifetime;
      res.status = dnsa_pkg::ST_OK;
      res.final_res = 1'b0;
    end else begin
      res.kind = 1'b1;
      res.address = '0;
      res.lifetime = '0;
      res.status = ev.status;
      res.final_res = 1'b1;
    end
    ev_pop = ev_valid && out_ready && !(send_rec && ev.fin);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) rec_done_r <= 1'b0;
    else if (ev_pop) rec_done_r <= 1'b0;
    else if (ev_valid && out_ready && send_rec) rec_done_r <= 1'b1;
  end

endmodule
